@@ rtl/core/vja_pkg.sv @@
// ============================================================================
// vja_pkg: shared types and constants for the vibration jerk alarm
// Field widths of the accelerometer samples, the squared-difference sum and
// the integer root, plus the axis bundle passed between modules.
// ============================================================================
package vja_pkg;

    localparam int AXIS_W    = 15;            // signed milli-g per axis
    localparam int DIFF_W    = AXIS_W + 1;    // signed sample-to-sample delta
    localparam int MAG_W     = AXIS_W;        // |delta| always fits 15 bits
    localparam int SQ_W      = 2 * MAG_W;     // one squared delta
    localparam int SUM_W     = SQ_W + 2;      // sum of three squares
    localparam int ROOT_W    = SUM_W / 2;     // floor root of the sum
    localparam int REM_W     = ROOT_W + 1;    // root remainder, <= 2*root
    localparam int LIMIT_W   = 16;
    localparam int OVER_W    = 2;             // shown count field
    localparam int OVER_MAX  = 3;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 16'd100;

    typedef struct packed {
        logic signed [AXIS_W-1:0] x;
        logic signed [AXIS_W-1:0] y;
        logic signed [AXIS_W-1:0] z;
    } t_axes;

    // start/done handshake of a multi-cycle unit
    typedef struct packed {
        logic start;
    } t_unit_req;

    typedef struct packed {
        logic busy;
        logic done;
    } t_unit_rsp;

endpackage

@@ rtl/core/vja_sqsum.sv @@
// ============================================================================
// vja_sqsum: sum of squared axis deltas on one shared multiplier
// One axis per cycle: delta, magnitude and square into a product register,
// then accumulation of that product on the following cycle.
// ============================================================================
module vja_sqsum (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  vja_pkg::t_unit_req           i_req,
    input  vja_pkg::t_axes               i_cur,
    input  vja_pkg::t_axes               i_last,
    output vja_pkg::t_unit_rsp           o_rsp,
    output logic [vja_pkg::SUM_W-1:0]    o_sum
);

    localparam logic [1:0] PH_X    = 2'd0;
    localparam logic [1:0] PH_Y    = 2'd1;
    localparam logic [1:0] PH_Z    = 2'd2;
    localparam logic [1:0] PH_LAST = 2'd3;

    logic                          r_busy;
    logic                          r_done;
    logic [1:0]                    r_phase;
    logic [vja_pkg::SQ_W-1:0]      r_prod;
    logic [vja_pkg::SUM_W-1:0]     r_acc;

    logic signed [vja_pkg::AXIS_W-1:0] a_cur;
    logic signed [vja_pkg::AXIS_W-1:0] a_last;
    logic signed [vja_pkg::DIFF_W-1:0] delta;
    logic signed [vja_pkg::DIFF_W-1:0] delta_abs;
    logic [vja_pkg::MAG_W-1:0]         mag;
    logic [vja_pkg::SQ_W-1:0]          n_prod;

    always_comb begin
        unique case (r_phase)
            PH_X: begin
                a_cur  = i_cur.x;
                a_last = i_last.x;
            end
            PH_Y: begin
                a_cur  = i_cur.y;
                a_last = i_last.y;
            end
            default: begin
                a_cur  = i_cur.z;
                a_last = i_last.z;
            end
        endcase
    end

    always_comb begin
        delta     = vja_pkg::DIFF_W'(a_cur) - vja_pkg::DIFF_W'(a_last);
        delta_abs = delta[vja_pkg::DIFF_W-1] ? -delta : delta;
        mag       = delta_abs[vja_pkg::MAG_W-1:0];
        n_prod    = vja_pkg::SQ_W'(mag) * vja_pkg::SQ_W'(mag);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_done  <= 1'b0;
            r_phase <= PH_X;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy  <= 1'b1;
                r_phase <= PH_X;
            end else if (r_busy) begin
                r_phase <= r_phase + 2'd1;
                if (r_phase == PH_LAST) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_acc <= '0;
        end else if (r_busy) begin
            if (r_phase != PH_LAST) r_prod <= n_prod;
            if (r_phase != PH_X)    r_acc  <= r_acc + vja_pkg::SUM_W'(r_prod);
        end
    end

    assign o_rsp.busy = r_busy;
    assign o_rsp.done = r_done;
    assign o_sum      = r_acc;

endmodule

@@ rtl/core/vja_isqrt.sv @@
// ============================================================================
// vja_isqrt: bit-serial integer square root, floor
// Restoring digit recurrence, one root bit per cycle on one subtractor.
// ============================================================================
module vja_isqrt (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  vja_pkg::t_unit_req           i_req,
    input  logic [vja_pkg::SUM_W-1:0]    i_radicand,
    output vja_pkg::t_unit_rsp           o_rsp,
    output logic [vja_pkg::ROOT_W-1:0]   o_root
);

    localparam int CNT_W = $clog2(vja_pkg::ROOT_W);
    localparam int TRY_W = vja_pkg::REM_W + 2;
    localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(vja_pkg::ROOT_W - 1);

    logic                          r_busy;
    logic                          r_done;
    logic [CNT_W-1:0]              r_step;
    logic [vja_pkg::SUM_W-1:0]     r_n;
    logic [vja_pkg::REM_W-1:0]     r_rem;
    logic [vja_pkg::ROOT_W-1:0]    r_root;

    logic [TRY_W-1:0] part;
    logic [TRY_W-1:0] trial;
    logic [TRY_W-1:0] diff;
    logic             fits;

    always_comb begin
        part  = {r_rem, r_n[vja_pkg::SUM_W-1 -: 2]};
        trial = {1'b0, r_root, 2'b01};
        diff  = part - trial;
        fits  = (part >= trial);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_step <= '0;
            end else if (r_busy) begin
                r_step <= r_step + CNT_W'(1);
                if (r_step == LAST_STEP) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_n    <= i_radicand;
            r_rem  <= '0;
            r_root <= '0;
        end else if (r_busy) begin
            r_n    <= {r_n[vja_pkg::SUM_W-3:0], 2'b00};
            r_rem  <= fits ? diff[vja_pkg::REM_W-1:0] : part[vja_pkg::REM_W-1:0];
            r_root <= {r_root[vja_pkg::ROOT_W-2:0], fits};
        end
    end

    assign o_rsp.busy = r_busy;
    assign o_rsp.done = r_done;
    assign o_root     = r_root;

endmodule

@@ rtl/core/vibration_jerk_alarm_top.sv @@
// ============================================================================
// vibration_jerk_alarm_top: sample-to-sample vibration alarm
// Vibration is floor(sqrt(dx^2+dy^2+dz^2)) against the previous sample; a
// run of samples at or above the limit raises a saturating count and alarm.
// ============================================================================
//
//  channel   handshake                  payload
//  --------  -------------------------  -----------------------------------
//  sample    i_in_valid / o_in_stall    i_accel_x, i_accel_y, i_accel_z
//  result    o_out_valid / i_out_stall  o_vibration, o_alarm, o_over_count
//  config    i_cfg_valid / o_cfg_ready  i_cfg_data (vibration limit)
//
//  From accept to result a sample beat passes the shared multiplier of the
//  square sum, a hand-over, the bit-serial root (one bit per cycle), and
//  the done state, which registers the result once the result slot is free.
//  o_in_stall is high from accept until the result is loaded; a new sample
//  can be taken while the result beat still waits on i_out_stall.
//  Reset is synchronous, active low; the limit resets to 100 milli-g.
//
module vibration_jerk_alarm_top #(
    parameter int ALARM_COUNT = 3
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // sample channel
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  logic signed [vja_pkg::AXIS_W-1:0]  i_accel_x,
    input  logic signed [vja_pkg::AXIS_W-1:0]  i_accel_y,
    input  logic signed [vja_pkg::AXIS_W-1:0]  i_accel_z,
    // result channel
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output logic [vja_pkg::ROOT_W-1:0]         o_vibration,
    output logic                               o_alarm,
    output logic [vja_pkg::OVER_W-1:0]         o_over_count,
    // config channel
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [vja_pkg::LIMIT_W-1:0]        i_cfg_data
);

    // run counter must be able to hold ALARM_COUNT itself
    localparam int CNT_W = $clog2(ALARM_COUNT + 1);
    localparam int EXT_W = CNT_W + vja_pkg::OVER_W;
    localparam logic [CNT_W-1:0] CNT_TOP = CNT_W'(ALARM_COUNT);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_SQ   = 4'b0010,
        S_ROOT = 4'b0100,
        S_DONE = 4'b1000
    } t_state;

    t_state r_state;
    t_state n_state;

    vja_pkg::t_axes              r_cur;
    vja_pkg::t_axes              r_last;
    logic                        r_have_last;
    logic                        r_first;      // this sample has no predecessor
    logic [CNT_W-1:0]            r_count;
    logic [vja_pkg::LIMIT_W-1:0] r_limit;

    logic                        r_out_valid;
    logic [vja_pkg::ROOT_W-1:0]  r_vib;
    logic                        r_alarm;
    logic [vja_pkg::OVER_W-1:0]  r_over;

    vja_pkg::t_unit_req          sq_req;
    vja_pkg::t_unit_rsp          sq_rsp;
    vja_pkg::t_unit_req          rt_req;
    vja_pkg::t_unit_rsp          rt_rsp;
    logic [vja_pkg::SUM_W-1:0]   sq_sum;
    logic [vja_pkg::ROOT_W-1:0]  rt_root;

    logic                        in_take;
    logic                        slot_free;
    logic                        load;
    logic [vja_pkg::ROOT_W-1:0]  n_vib;
    logic [CNT_W-1:0]            n_count;
    logic [EXT_W-1:0]            count_ext;

    assign in_take   = i_in_valid && (r_state == S_IDLE);
    assign slot_free = !r_out_valid || !i_out_stall;
    assign load      = (r_state == S_DONE) && slot_free;

    assign sq_req.start = in_take;
    assign rt_req.start = sq_rsp.done;

    vja_sqsum u_sqsum (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (sq_req),
        .i_cur   (r_cur),
        .i_last  (r_last),
        .o_rsp   (sq_rsp),
        .o_sum   (sq_sum)
    );

    vja_isqrt u_isqrt (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (rt_req),
        .i_radicand (sq_sum),
        .o_rsp      (rt_rsp),
        .o_root     (rt_root)
    );

    // sequencer
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (in_take)     n_state = S_SQ;
            S_SQ:    if (sq_rsp.done) n_state = S_ROOT;
            S_ROOT:  if (rt_rsp.done) n_state = S_DONE;
            S_DONE:  if (slot_free)   n_state = S_IDLE;
            default:                  n_state = S_IDLE;
        endcase
    end

    // first sample reports zero; compare and run count follow
    always_comb begin
        n_vib = r_first ? '0 : rt_root;
        if (n_vib >= r_limit) begin
            n_count = (r_count < CNT_TOP) ? r_count + CNT_W'(1) : r_count;
        end else begin
            n_count = '0;
        end
        count_ext = EXT_W'(n_count);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_have_last <= 1'b0;
            r_count     <= '0;
            r_limit     <= vja_pkg::LIMIT_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid) r_limit <= i_cfg_data;
            if (load) begin
                r_have_last <= 1'b1;
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_cur.x <= i_accel_x;
            r_cur.y <= i_accel_y;
            r_cur.z <= i_accel_z;
            r_first <= !r_have_last;
        end
        if (load) begin
            r_last  <= r_cur;
            r_vib   <= n_vib;
            r_alarm <= (n_count >= CNT_TOP);
            r_over  <= (count_ext > EXT_W'(vja_pkg::OVER_MAX)) ?
                       vja_pkg::OVER_W'(vja_pkg::OVER_MAX) :
                       count_ext[vja_pkg::OVER_W-1:0];
        end
    end

    // r_last is payload: before the first load it is unused (r_first masks it)
    always_comb begin
        o_in_stall   = (r_state != S_IDLE);
        o_out_valid  = r_out_valid;
        o_vibration  = r_vib;
        o_alarm      = r_alarm;
        o_over_count = r_over;
        o_cfg_ready  = 1'b1;
    end

    // ---------------------------------------------------------------- checks
    a_sq_done_in_sq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        sq_rsp.done |-> (r_state == S_SQ))
        else $error("square sum finished outside its phase");

    a_root_done_in_root: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rt_rsp.done |-> (r_state == S_ROOT))
        else $error("root finished outside its phase");

    a_units_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(sq_rsp.busy && rt_rsp.busy))
        else $error("shared units active together");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_TOP)
        else $error("run count beyond alarm count");

    a_alarm_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_alarm) |-> (o_over_count != '0))
        else $error("alarm with zero count");

endmodule

@@ verif/vibration_jerk_alarm_top_tb.sv @@
`timescale 1ns / 1ps
// ============================================================================
// vibration_jerk_alarm_top_tb: self-checking bench for the vibration alarm
// Drives accelerometer sample beats, predicts vibration, alarm and run count
// per sample, and checks every result beat in order. The limit register is
// rewritten between phases while the block is drained.
// ============================================================================
module vibration_jerk_alarm_top_tb;

    localparam int ALARM_RUN   = 3;
    localparam int CYCLE_LIMIT = 300000;
    localparam int IDLE_PCT    = 22;
    localparam int HOLD_CYCLES = 400;

    typedef struct packed {
        logic [vja_pkg::ROOT_W-1:0] vibration;
        logic                       alarm;
        logic [vja_pkg::OVER_W-1:0] over_count;
    } t_result;

    // ------------------------------------------------------------------
    // DUT ports; every input starts at a known value
    // ------------------------------------------------------------------
    logic                              i_clk        = 1'b0;
    logic                              i_rst_n      = 1'b0;
    logic                              i_in_valid   = 1'b0;
    logic                              o_in_stall;
    logic signed [vja_pkg::AXIS_W-1:0] i_accel_x    = '0;
    logic signed [vja_pkg::AXIS_W-1:0] i_accel_y    = '0;
    logic signed [vja_pkg::AXIS_W-1:0] i_accel_z    = '0;
    logic                              o_out_valid;
    logic                              i_out_stall  = 1'b0;
    logic [vja_pkg::ROOT_W-1:0]        o_vibration;
    logic                              o_alarm;
    logic [vja_pkg::OVER_W-1:0]        o_over_count;
    logic                              i_cfg_valid  = 1'b0;
    logic                              o_cfg_ready;
    logic [vja_pkg::LIMIT_W-1:0]       i_cfg_data   = '0;

    vibration_jerk_alarm_top #(
        .ALARM_COUNT (ALARM_RUN)
    ) uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_accel_x    (i_accel_x),
        .i_accel_y    (i_accel_y),
        .i_accel_z    (i_accel_z),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_vibration  (o_vibration),
        .o_alarm      (o_alarm),
        .o_over_count (o_over_count),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_data   (i_cfg_data)
    );

    // ------------------------------------------------------------------
    // Bench state
    // ------------------------------------------------------------------
    vja_pkg::t_axes pending_samples[$];     // sample beats not yet offered
    t_result        expected_results[$];    // predictions waiting for result beats

    // predictor's copy of the block state and the limit register
    logic [vja_pkg::LIMIT_W-1:0] limit_model = vja_pkg::LIMIT_RESET;
    vja_pkg::t_axes              prev_sample = '0;
    bit                          have_prev   = 1'b0;
    int unsigned                 over_run    = 0;

    // last queued sample, used to shape deltas of the next one
    int gen_x = 0;
    int gen_y = 0;
    int gen_z = 0;

    bit no_idle   = 1'b0;            // set for the stretch without gaps
    int hold_left = 0;
    bit hold_done = 1'b0;

    int cycle_count   = 0;
    int samples_in    = 0;
    int result_beats  = 0;
    int alarm_beats   = 0;
    int peak_vib      = 0;
    int fault_count   = 0;
    int limit_writes  = 0;

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Predictor: floor root of the squared-delta sum, then the run count
    // ------------------------------------------------------------------
    function automatic t_result predict_vibration(input vja_pkg::t_axes s);
        longint      dx, dy, dz;
        longint      sum;
        longint      trial;
        int unsigned root;
        t_result     r;
        root = 0;
        if (have_prev) begin
            dx  = longint'($signed(s.x)) - longint'($signed(prev_sample.x));
            dy  = longint'($signed(s.y)) - longint'($signed(prev_sample.y));
            dz  = longint'($signed(s.z)) - longint'($signed(prev_sample.z));
            sum = dx * dx + dy * dy + dz * dz;
            // bitwise search from the top; 16 bits cap the root at 65535
            for (int b = vja_pkg::ROOT_W - 1; b >= 0; b--) begin
                trial = longint'(root | (32'd1 << b));
                if (trial * trial <= sum)
                    root = root | (32'd1 << b);
            end
        end
        prev_sample = s;
        have_prev   = 1'b1;
        if (root >= limit_model) begin
            if (over_run < ALARM_RUN)
                over_run++;
        end else begin
            over_run = 0;
        end
        r.vibration  = root[vja_pkg::ROOT_W-1:0];
        r.alarm      = (over_run >= ALARM_RUN);
        r.over_count = (over_run > vja_pkg::OVER_MAX) ?
                       vja_pkg::OVER_W'(vja_pkg::OVER_MAX) :
                       vja_pkg::OVER_W'(over_run);
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Sample driver: next beat only when the line is free or just taken
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : sample_driver
        vja_pkg::t_axes next_s;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                expected_results.push_back(
                    predict_vibration('{x: i_accel_x, y: i_accel_y, z: i_accel_z}));
                samples_in <= samples_in + 1;
            end
            if (!i_in_valid || !o_in_stall) begin
                if (pending_samples.size() != 0 &&
                    (no_idle || $urandom_range(0, 99) >= IDLE_PCT)) begin
                    next_s = pending_samples.pop_front();
                    i_accel_x  <= next_s.x;
                    i_accel_y  <= next_s.y;
                    i_accel_z  <= next_s.z;
                    i_in_valid <= 1'b1;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Result receiver: random stalls, plus one long hold-off mid-run while
    // samples keep coming so the block backs up and stalls its input
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : result_receiver
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left   <= hold_left - 1;
            i_out_stall <= 1'b1;
        end else if (!hold_done && result_beats > 150 && pending_samples.size() > 10) begin
            hold_left   <= HOLD_CYCLES;
            hold_done   <= 1'b1;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= !no_idle && ($urandom_range(0, 99) < IDLE_PCT);
        end
    end

    // ------------------------------------------------------------------
    // Result monitor: compare each accepted beat with the oldest prediction
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : result_monitor
        t_result want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            result_beats <= result_beats + 1;
            if (o_alarm === 1'b1)
                alarm_beats <= alarm_beats + 1;
            if (int'(o_vibration) > peak_vib)
                peak_vib <= int'(o_vibration);
            if (expected_results.size() == 0) begin
                if (fault_count < 10)
                    $display("[%0t] unexpected result beat: vib=%0d alarm=%0d count=%0d",
                             $realtime, o_vibration, o_alarm, o_over_count);
                fault_count <= fault_count + 1;
            end else begin
                want = expected_results.pop_front();
                if (o_vibration !== want.vibration || o_alarm !== want.alarm ||
                    o_over_count !== want.over_count) begin
                    if (fault_count < 10) begin
                        $display("[%0t] mismatch: exp vib=%0d alarm=%0d count=%0d",
                                 $realtime, want.vibration, want.alarm,
                                 want.over_count);
                        $display("            got vib=%0d alarm=%0d count=%0d",
                                 o_vibration, o_alarm, o_over_count);
                    end
                    fault_count <= fault_count + 1;
                end
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin : watchdog
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, expected_results.size());
            $display("FAIL");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    task automatic push_sample(input int x, input int y, input int z);
        vja_pkg::t_axes s;
        s.x = x[vja_pkg::AXIS_W-1:0];
        s.y = y[vja_pkg::AXIS_W-1:0];
        s.z = z[vja_pkg::AXIS_W-1:0];
        pending_samples.push_back(s);
        gen_x = x;
        gen_y = y;
        gen_z = z;
    endtask

    // move one axis by d in a random direction, staying inside 15 bits
    function automatic int step_axis(input int p, input int d);
        int n;
        if ($urandom_range(0, 1))
            d = -d;
        n = p + d;
        if (n > 16383 || n < -16384)
            n = p - d;
        if (n > 16383 || n < -16384)
            n = $urandom_range(0, 32767) - 16384;
        return n;
    endfunction

    task automatic write_limit(input logic [vja_pkg::LIMIT_W-1:0] value);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        limit_model = value;
        limit_writes++;
    endtask

    task automatic wait_drained();
        do @(posedge i_clk);
        while (pending_samples.size() != 0 || i_in_valid || expected_results.size() != 0);
    endtask

    // Bursts of jerks at or just over the limit build runs; corner flips
    // reach the largest roots; the rest is near-limit, calm and noise.
    task automatic queue_random_samples(input int count,
                                        input logic [vja_pkg::LIMIT_W-1:0] lim);
        int left, burst, kind, sub, d, ax, nx, ny, nz, span;
        left = count;
        span = (lim > 32767) ? 32767 : int'(lim);
        while (left > 0) begin
            burst = $urandom_range(1, 6);
            kind  = $urandom_range(0, 99);
            for (int k = 0; k < burst && left > 0; k++) begin
                nx = gen_x;
                ny = gen_y;
                nz = gen_z;
                sub = $urandom_range(0, 99);
                if (kind < 40) begin
                    d  = span + $urandom_range(0, span / 4 + 2);
                    ax = $urandom_range(0, 2);
                    case (ax)
                        0: nx = step_axis(gen_x, d);
                        1: ny = step_axis(gen_y, d);
                        default: nz = step_axis(gen_z, d);
                    endcase
                end else if (kind < 55) begin
                    nx = (gen_x < 0) ? 16383 : -16384;
                    ny = (gen_y < 0) ? 16383 : -16384;
                    nz = (gen_z < 0) ? 16383 : -16384;
                end else if (sub < 30) begin
                    d  = (span == 0) ? 0 : span - 1 + $urandom_range(0, 1);
                    nx = step_axis(gen_x, d);
                end else if (sub < 60) begin
                    nx = step_axis(gen_x, $urandom_range(0, span / 2));
                    ny = step_axis(gen_y, $urandom_range(0, span / 4));
                end else if (sub < 80) begin
                    nx = $urandom_range(0, 32767) - 16384;
                    ny = $urandom_range(0, 32767) - 16384;
                    nz = $urandom_range(0, 32767) - 16384;
                end else begin
                    nx = $urandom_range(0, 32000) - 16000;
                    ny = $urandom_range(0, 32000) - 16000;
                    nz = $urandom_range(0, 32000) - 16000;
                end
                push_sample(nx, ny, nz);
                left--;
            end
        end
    endtask

    task automatic run_phase(input logic [vja_pkg::LIMIT_W-1:0] lim, input int count,
                             input bit gapless);
        write_limit(lim);
        @(negedge i_clk);
        no_idle = gapless;
        queue_random_samples(count, lim);
        wait_drained();
        @(negedge i_clk);
        no_idle = 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial begin : test_sequence
        logic [vja_pkg::LIMIT_W-1:0] phase_limit [8];
        phase_limit[0] = 16'd0;
        phase_limit[1] = 16'd65535;
        phase_limit[2] = 16'd300;
        phase_limit[3] = 16'd1;
        phase_limit[4] = 16'd56754;       // exactly the largest reachable root
        phase_limit[5] = 16'($urandom_range(2, 3000));
        phase_limit[6] = 16'($urandom_range(0, 65535));
        phase_limit[7] = 16'd2000;

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // first sample after reset under a zero limit still counts as over;
        // zero deltas then saturate the run and raise the alarm
        write_limit(16'd0);
        @(negedge i_clk);
        repeat (4) push_sample(0, 0, 0);
        wait_drained();

        write_limit(vja_pkg::LIMIT_RESET);
        @(negedge i_clk);
        push_sample(16383, 16383, 16383);
        push_sample(-16384, -16384, -16384);   // full-scale delta on all axes
        push_sample(-16384, -16384, -16384);
        push_sample(-16284, -16384, -16384);   // delta equal to the limit
        push_sample(-16184, -16384, -16384);
        push_sample(-16084, -16384, -16384);   // alarm
        push_sample(-15984, -16384, -16384);   // count saturates
        push_sample(-15885, -16384, -16384);   // one under: run clears
        push_sample(-15825, -16304, -16384);   // 60/80 pair, exact root 100
        push_sample(-15768, -16247, -16327);   // root 98.7 floors below
        push_sample(16383, -16384, 0);
        push_sample(-1, -1, -1);
        push_sample(0, 0, 0);
        push_sample(16000, -16000, 16000);
        push_sample(-16000, 16000, -16000);
        push_sample(16383, 0, -16384);
        wait_drained();

        for (int p = 0; p < 8; p++)
            run_phase(phase_limit[p], 70, p == 3);

        // let any stray beat show up before the verdict
        repeat (60) @(posedge i_clk);

        $display("ran %0d samples under %0d limit writes; %0d results, %0d with alarm",
                 samples_in, limit_writes, result_beats, alarm_beats);
        $display("peak vibration %0d milli-g, %0d faults, %0d results outstanding",
                 peak_vib, fault_count, expected_results.size());
        if (fault_count == 0 && expected_results.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

@@ files.f @@
rtl/core/vja_pkg.sv
rtl/core/vja_sqsum.sv
rtl/core/vja_isqrt.sv
rtl/core/vibration_jerk_alarm_top.sv
verif/vibration_jerk_alarm_top_tb.sv
